// ===== rtl/core/olist_pkg.sv =====
// Shared types, codes and sizes of the ordered list engine.
package olist_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MODE_W = 4;
	localparam int POS_W = 6;
	localparam int DATA_W = 32;
	localparam int STAT_W = 3;
	localparam int IDX_W = 6;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 4'd0,
		MODE_INS_BACK  = 4'd1,
		MODE_INS_POS   = 4'd2,
		MODE_DEL_FRONT = 4'd3,
		MODE_DEL_BACK  = 4'd4,
		MODE_DEL_POS   = 4'd5,
		MODE_CLEAR     = 4'd6,
		MODE_COUNT     = 4'd7,
		MODE_SEARCH    = 4'd8,
		MODE_NTH       = 4'd9,
		MODE_DUMP      = 4'd10
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 3'd0,
		STAT_EMPTY = 3'd1,
		STAT_NOPOS = 3'd2,
		STAT_FULL  = 3'd3,
		STAT_MISS  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD,
		S_USE,
		S_INS_WR,
		S_REPLY
	} seq_state_t;

	typedef enum logic [2:0] {
		OP_INS,
		OP_DEL,
		OP_SRCH,
		OP_NTH,
		OP_DUMP
	} op_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] data;
		logic [IDX_W-1:0]         index;
		logic                     last;
	} out_item_t;

endpackage

// ===== rtl/core/olist_if.sv =====
// Valid/ready channel carrying one beat of a typed payload.
interface olist_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ordered_list_engine.sv =====
// Ordered list engine: top level with the list memory, sequencer and result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a
// synchronous memory. Requests arrive on the req channel, one beat per
// operation (insert, delete, clear, count, search, nth read, dump); results
// leave on the rsp channel, one beat per operation, or one beat per element
// for a non-empty dump, with last set on the final beat of each request.
// One request is handled at a time; req is ready only while the sequencer is idle.
// An operation that touches no element goes from the dispatch state straight to the
// reply state, which hands its result to the output register. Every element read, compared or moved
// passes through a read state and a use state, as each memory access waits for registered
// read data, so a dump delivers one beat per read and use pass, and an insert or delete
// takes one such pass per element it walks over.
// Results pass through an output register, so the sequencer keeps working while
// one beat waits; if rsp stalls further, the sequencer holds its place until the
// register frees.
// Reset clears the element count, the sequencer state and the output valid flag; memory contents need no
// clearing since only entries below the count are ever read.
module ordered_list_engine #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	olist_if.sink  req,
	olist_if.source rsp
);
	import olist_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic out_free;
	logic res_push;
	out_item_t res;
	logic valid_q;
	out_item_t res_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	assign out_free = !valid_q || rsp.ready;
	assign rsp.valid = valid_q;
	assign rsp.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_push) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

	olist_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.out_free(out_free),
		.res_push(res_push),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	olist_ram #(
		.W(DATA_W),
		.D(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule

// ===== rtl/core/olist_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module olist_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/olist_seq.sv =====
// Sequencer that walks the list memory for each operation, reading and then using one entry at a time.
module olist_seq #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	olist_if.sink                             req,
	input  logic                              out_free,
	output logic                              res_push,
	output olist_pkg::out_item_t              res,
	output logic                              ram_we,
	output logic [$clog2(CAPACITY)-1:0]       ram_waddr,
	output logic [olist_pkg::DATA_W-1:0]      ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(CAPACITY)-1:0]       ram_raddr,
	input  logic [olist_pkg::DATA_W-1:0]      ram_rdata
);
	import olist_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	seq_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;

	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0] pos_q;
	logic [DATA_W-1:0] value_q;
	op_t op_q;
	logic [AW-1:0] ptr_q, ins_pos_q;
	status_t st_q;
	logic [DATA_W-1:0] rdat_q;
	logic use_ptr_q, first_q;

	mode_t mode_e;
	logic [CMPW-1:0] cnt_ext, pos_ext, ins_p, del_p;
	logic full, empty, at_end, match;

	seq_state_t dsp_state;
	op_t dsp_op;
	logic [AW-1:0] dsp_ptr;
	status_t dsp_st;
	logic dsp_clear;

	assign mode_e = mode_t'(mode_q);
	assign cnt_ext = CMPW'(cnt_q);
	assign pos_ext = CMPW'(pos_q);
	assign full = cnt_q >= CW'(CAPACITY);
	assign empty = cnt_q == '0;
	assign at_end = (CW'(ptr_q) + CW'(1)) == cnt_q;
	assign match = ram_rdata == value_q;

	assign ins_p = (mode_e == MODE_INS_FRONT) ? '0 :
		(mode_e == MODE_INS_BACK) ? cnt_ext : pos_ext;
	assign del_p = (mode_e == MODE_DEL_FRONT) ? '0 :
		(mode_e == MODE_DEL_BACK) ? cnt_ext - CMPW'(1) : pos_ext;

	assign req.ready = state_q == S_IDLE;

	// Decide, from the latched request and the current count, what the operation does.
	always_comb begin
		dsp_state = S_REPLY;
		dsp_op = OP_NTH;
		dsp_ptr = '0;
		dsp_st = STAT_OK;
		dsp_clear = 1'b0;
		case (mode_e)
			MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
				if (full) begin
					dsp_st = STAT_FULL;
				end else if (ins_p > cnt_ext) begin
					dsp_st = STAT_NOPOS;
				end else begin
					dsp_op = OP_INS;
					if (ins_p < cnt_ext) begin
						dsp_ptr = AW'(cnt_ext - CMPW'(1));
						dsp_state = S_RD;
					end else begin
						dsp_state = S_INS_WR;
					end
				end
			end
			MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
				if (empty) begin
					dsp_st = STAT_EMPTY;
				end else if (del_p >= cnt_ext) begin
					dsp_st = STAT_NOPOS;
				end else begin
					dsp_op = OP_DEL;
					dsp_ptr = AW'(del_p);
					dsp_state = S_RD;
				end
			end
			MODE_CLEAR: begin
				dsp_clear = 1'b1;
			end
			MODE_COUNT: begin
				dsp_st = STAT_OK;
			end
			MODE_SEARCH: begin
				if (empty) begin
					dsp_st = STAT_MISS;
				end else begin
					dsp_op = OP_SRCH;
					dsp_state = S_RD;
				end
			end
			MODE_NTH: begin
				if (pos_ext < cnt_ext) begin
					dsp_op = OP_NTH;
					dsp_ptr = AW'(pos_ext);
					dsp_state = S_RD;
				end else begin
					dsp_st = STAT_NOPOS;
				end
			end
			MODE_DUMP: begin
				if (empty) begin
					dsp_st = STAT_EMPTY;
				end else begin
					dsp_op = OP_DUMP;
					dsp_state = S_RD;
				end
			end
			default: begin
				dsp_st = STAT_OK;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: state_d = dsp_state;
			S_RD: state_d = S_USE;
			S_USE: begin
				case (op_q)
					OP_INS: state_d = (ptr_q == ins_pos_q) ? S_INS_WR : S_RD;
					OP_DEL: state_d = at_end ? S_REPLY : S_RD;
					OP_SRCH: state_d = (match || at_end) ? S_REPLY : S_RD;
					OP_NTH: state_d = S_REPLY;
					OP_DUMP: begin
						if (out_free) begin
							state_d = at_end ? S_IDLE : S_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INS_WR: state_d = S_REPLY;
			S_REPLY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_re = 1'b0;
		ram_raddr = ptr_q;
		ram_we = 1'b0;
		ram_waddr = ins_pos_q;
		ram_wdata = value_q;
		res_push = 1'b0;
		res = '0;
		case (state_q)
			S_RD: ram_re = 1'b1;
			S_USE: begin
				ram_wdata = ram_rdata;
				case (op_q)
					OP_INS: begin
						// Shifting towards the back: the entry just read moves up by one.
						ram_we = 1'b1;
						ram_waddr = ptr_q + AW'(1);
					end
					OP_DEL: begin
						ram_we = !first_q;
						ram_waddr = ptr_q - AW'(1);
					end
					OP_DUMP: begin
						res_push = out_free;
						res.status = STAT_OK;
						res.data = ram_rdata;
						res.index = IDX_W'(ptr_q);
						res.last = at_end;
					end
					default: ram_we = 1'b0;
				endcase
			end
			S_INS_WR: ram_we = 1'b1;
			S_REPLY: begin
				res_push = out_free;
				res.status = st_q;
				res.data = rdat_q;
				res.index = use_ptr_q ? IDX_W'(ptr_q) : IDX_W'(cnt_q);
				res.last = 1'b1;
			end
			default: res_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DISPATCH && dsp_clear) begin
				cnt_q <= '0;
			end else if (state_q == S_INS_WR) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == S_USE && op_q == OP_DEL && at_end) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					mode_q <= req.payload.mode;
					pos_q <= req.payload.position;
					value_q <= req.payload.value;
				end
			end
			S_DISPATCH: begin
				op_q <= dsp_op;
				ptr_q <= dsp_ptr;
				ins_pos_q <= AW'(ins_p);
				st_q <= dsp_st;
				rdat_q <= '0;
				use_ptr_q <= 1'b0;
				first_q <= 1'b1;
			end
			S_USE: begin
				first_q <= 1'b0;
				case (op_q)
					OP_INS: begin
						if (ptr_q != ins_pos_q) begin
							ptr_q <= ptr_q - AW'(1);
						end
					end
					OP_DEL: begin
						// The first entry read is the one being removed.
						if (first_q) begin
							rdat_q <= ram_rdata;
						end
						if (!at_end) begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
					OP_SRCH: begin
						if (match) begin
							use_ptr_q <= 1'b1;
						end else if (at_end) begin
							st_q <= STAT_MISS;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
					OP_NTH: rdat_q <= ram_rdata;
					OP_DUMP: begin
						if (out_free && !at_end) begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
					default: first_q <= 1'b0;
				endcase
			end
			default: first_q <= first_q;
		endcase
	end
endmodule
